// ===== hw/rtl/lefc_pkg.sv =====
package lefc_pkg;

    // header layout, byte offsets into the little-endian entry header
    localparam int HDR_BYTES = 32;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int OFF_FP    = 8;
    localparam int OFF_ELEN  = 16;
    localparam int OFF_VLEN  = 20;
    localparam int OFF_KLEN  = 24;
    localparam int OFF_FLAGS = 26;
    localparam int OFF_CRC   = 28;

    // crc32c, reflected form
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] sequence_number;
        logic [63:0] key_fingerprint;
        logic [15:0] entry_flags;
        logic [15:0] key_length;
        logic [31:0] value_length;
    } t_result;

    // one byte through the crc register, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/lefc_in_stage.sv =====
module lefc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_data_byte
);
    logic       r_valid;
    logic [7:0] r_byte;

    // a held byte may be replaced in the cycle it moves on
    assign o_ready = !r_valid || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_byte;
endmodule

// ===== hw/rtl/lefc_parser.sv =====
module lefc_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic [31:0]          i_max_len,
    output logic                 o_res_valid,
    output lefc_pkg::t_result    o_res
);
    import lefc_pkg::*;

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase               r_phase;
    logic [HDR_IDX_W-1:0] r_hdr_cnt;
    logic [7:0]           r_hdr [HDR_BYTES];
    logic [32:0]          r_rem;
    logic [31:0]          r_crc;

    logic [7:0]  hv [HDR_BYTES];
    logic        in_header;
    logic        last_hdr;
    logic [7:0]  crc_in;
    logic [31:0] crc_nx;
    logic [31:0] elen;
    logic [31:0] vlen;
    logic [15:0] klen;
    logic [31:0] stored_crc;
    logic [32:0] pay_len;
    logic [33:0] total_len;
    logic        len_bad;
    logic        crc_ok;
    logic        pay_done;

    assign in_header = (r_phase == PH_HEADER);
    assign last_hdr  = in_header && (r_hdr_cnt == HDR_IDX_W'(HDR_BYTES - 1));

    // header as it stands once this byte is in
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hv[i] = (in_header && (r_hdr_cnt == HDR_IDX_W'(i))) ? i_data_byte : r_hdr[i];
        end
    end

    // header fields
    always_comb begin
        o_res = '0;
        elen       = '0;
        stored_crc = '0;
        for (int i = 0; i < 8; i++) begin
            o_res.sequence_number[8*i +: 8] = hv[i];
            o_res.key_fingerprint[8*i +: 8] = hv[OFF_FP + i];
        end
        for (int i = 0; i < 4; i++) begin
            elen[8*i +: 8]                = hv[OFF_ELEN + i];
            o_res.value_length[8*i +: 8]  = hv[OFF_VLEN + i];
            stored_crc[8*i +: 8]          = hv[OFF_CRC + i];
        end
        for (int i = 0; i < 2; i++) begin
            o_res.key_length[8*i +: 8]  = hv[OFF_KLEN + i];
            o_res.entry_flags[8*i +: 8] = hv[OFF_FLAGS + i];
        end
        o_res.status = STATUS_OK;
        if (last_hdr && len_bad) begin
            o_res.status = STATUS_LEN_ERR;
        end else if (!crc_ok) begin
            o_res.status = STATUS_CRC_ERR;
        end
    end

    assign vlen = o_res.value_length;
    assign klen = o_res.key_length;

    // crc update, stored crc bytes go in as zero
    assign crc_in = (in_header && (r_hdr_cnt >= HDR_IDX_W'(OFF_CRC))) ? 8'd0 : i_data_byte;
    assign crc_nx = crc_byte(r_crc, crc_in);
    assign crc_ok = (~crc_nx == stored_crc);

    // length check
    assign pay_len   = {17'd0, klen} + {1'b0, vlen};
    assign total_len = {1'b0, pay_len} + 34'(HDR_BYTES);
    assign len_bad   = (elen < 32'(HDR_BYTES)) || (elen > i_max_len)
                       || (total_len != {2'b00, elen});

    assign pay_done    = !in_header && (r_rem <= 33'd1);
    assign o_res_valid = i_step && ((last_hdr && (len_bad || pay_len == '0)) || pay_done);

    // phase, counters and crc register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_cnt <= '0;
            r_rem     <= '0;
            r_crc     <= CRC_INIT;
        end else if (i_step) begin
            unique case (r_phase)
                PH_HEADER: begin
                    r_hdr_cnt <= r_hdr_cnt + 1'b1;
                    r_crc     <= crc_nx;
                    if (last_hdr) begin
                        r_hdr_cnt <= '0;
                        if (len_bad || pay_len == '0) begin
                            r_crc <= CRC_INIT;
                        end else begin
                            r_phase <= PH_PAYLOAD;
                            r_rem   <= pay_len;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    r_crc <= crc_nx;
                    r_rem <= r_rem - 1'b1;
                    if (pay_done) begin
                        r_phase <= PH_HEADER;
                        r_rem   <= '0;
                        r_crc   <= CRC_INIT;
                    end
                end
                default: begin
                    r_phase <= PH_HEADER;
                end
            endcase
        end
    end

    // header byte store
    always_ff @(posedge i_clk) begin
        if (i_step && in_header) begin
            r_hdr[r_hdr_cnt] <= i_data_byte;
        end
    end
endmodule

// ===== hw/rtl/lefc_out_stage.sv =====
module lefc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  lefc_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output lefc_pkg::t_result o_res
);
    import lefc_pkg::*;

    logic    r_valid;
    t_result r_res;

    // slot can load when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== hw/rtl/log_entry_frame_checker.sv =====
// an entry's last byte passes the input register and the parser, and its result is
// held in the output register; throughput: one byte per cycle while nothing stalls,
// set by the bytewise crc32c step in the parser; an unread result in the output
// register stalls the parser, and the input stalls while its held byte is not taken
// reset (i_rst_n low, synchronous) empties both registers, returns to header
// parsing, sets the crc to all ones and max entry length to 0xFFFFFFFF
module log_entry_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_sequence_number,
    output logic [63:0] o_key_fingerprint,
    output logic [15:0] o_entry_flags,
    output logic [15:0] o_key_length,
    output logic [31:0] o_value_length
);
    import lefc_pkg::*;

    logic [31:0] r_max_len;
    logic        in_valid;
    logic [7:0]  in_byte;
    logic        out_free;
    logic        step;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    // max entry length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 32'hFFFF_FFFF;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    assign step = in_valid && out_free;

    lefc_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_take      (step),
        .o_valid     (in_valid),
        .o_data_byte (in_byte)
    );

    lefc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (in_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lefc_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (out_res)
    );

    assign o_status          = out_res.status;
    assign o_sequence_number = out_res.sequence_number;
    assign o_key_fingerprint = out_res.key_fingerprint;
    assign o_entry_flags     = out_res.entry_flags;
    assign o_key_length      = out_res.key_length;
    assign o_value_length    = out_res.value_length;
endmodule

// ===== hw/rtl/lefc_checker.sv =====
module lefc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [63:0] o_sequence_number
);
    import lefc_pkg::*;

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_valid)
        else $error("result valid right after reset");

    // status only takes defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_LEN_ERR
                     || o_status == STATUS_CRC_ERR))
        else $error("undefined status code");

    // with the result slot empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result slot");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
                                   && $stable(o_sequence_number)))
        else $error("stalled result changed");
endmodule

bind log_entry_frame_checker lefc_checker u_lefc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_status          (o_status),
    .o_sequence_number (o_sequence_number)
);

// ===== tb/log_entry_frame_checker_tb.sv =====
`timescale 1ns / 100ps

module log_entry_frame_checker_tb;
    import lefc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int STALL_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_BYTES    = 140;
    localparam int PHASE_ENTRIES  = 3;
    localparam int REPORT_LIMIT   = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte   = 8'h00;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'h0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [1:0]  o_status;
    logic [63:0] o_sequence_number;
    logic [63:0] o_key_fingerprint;
    logic [15:0] o_entry_flags;
    logic [15:0] o_key_length;
    logic [31:0] o_value_length;

    // stream parser shadow state
    logic [255:0] hdr_shadow   = '0;
    int unsigned  hdr_count    = 0;
    bit           in_payload   = 1'b0;
    logic [32:0]  payload_left = '0;
    logic [31:0]  crc_run      = CRC_INIT;
    logic [31:0]  max_len_cfg  = 32'hFFFF_FFFF;
    t_result      entry_results_q[$];

    // traffic shaping and bookkeeping
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    int entries_sent = 0;
    int cfg_writes   = 0;
    int ok_seen      = 0;
    int len_err_seen = 0;
    int crc_err_seen = 0;
    int mismatches   = 0;

    log_entry_frame_checker dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_sequence_number (o_sequence_number),
        .o_key_fingerprint (o_key_fingerprint),
        .o_entry_flags     (o_entry_flags),
        .o_key_length      (o_key_length),
        .o_value_length    (o_value_length)
    );

    // 100 MHz clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // crc32c, one data bit folded in per shift
    function automatic logic [31:0] crc32c_shift_in(input logic [31:0] crc,
                                                    input logic [7:0] data);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // result fields come straight from the captured header
    function automatic t_result entry_result(input logic [1:0] st);
        t_result r;
        r.status          = st;
        r.sequence_number = hdr_shadow[63:0];
        r.key_fingerprint = hdr_shadow[OFF_FP*8 +: 64];
        r.entry_flags     = hdr_shadow[OFF_FLAGS*8 +: 16];
        r.key_length      = hdr_shadow[OFF_KLEN*8 +: 16];
        r.value_length    = hdr_shadow[OFF_VLEN*8 +: 32];
        return r;
    endfunction

    function automatic logic [1:0] crc_verdict();
        return (~crc_run == hdr_shadow[OFF_CRC*8 +: 32]) ? STATUS_OK : STATUS_CRC_ERR;
    endfunction

    // advance the shadow parser by one accepted byte
    task automatic predict_byte(input logic [7:0] b);
        logic [31:0] elen;
        logic [33:0] span;
        if (!in_payload) begin
            hdr_shadow[8*hdr_count +: 8] = b;
            crc_run = crc32c_shift_in(crc_run, (hdr_count >= OFF_CRC) ? 8'h00 : b);
            hdr_count++;
            if (hdr_count == HDR_BYTES) begin
                hdr_count = 0;
                elen = hdr_shadow[OFF_ELEN*8 +: 32];
                span = 34'(HDR_BYTES) + 34'(hdr_shadow[OFF_KLEN*8 +: 16])
                     + 34'(hdr_shadow[OFF_VLEN*8 +: 32]);
                if (elen < 32'(HDR_BYTES) || elen > max_len_cfg || span != 34'(elen)) begin
                    entry_results_q.push_back(entry_result(STATUS_LEN_ERR));
                    crc_run = CRC_INIT;
                end else if (span == 34'(HDR_BYTES)) begin
                    // header-only entry closes right here
                    entry_results_q.push_back(entry_result(crc_verdict()));
                    crc_run = CRC_INIT;
                end else begin
                    in_payload   = 1'b1;
                    payload_left = 33'(span - 34'(HDR_BYTES));
                end
            end
        end else begin
            crc_run = crc32c_shift_in(crc_run, b);
            payload_left--;
            if (payload_left == 0) begin
                entry_results_q.push_back(entry_result(crc_verdict()));
                crc_run    = CRC_INIT;
                in_payload = 1'b0;
            end
        end
    endtask

    // one byte transfer, with optional idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_byte(b);
        bytes_sent++;
    endtask

    // build a header, add payload only when the lengths will pass
    task automatic send_entry(input logic [63:0] seq, input logic [63:0] fp,
                              input logic [15:0] flags, input logic [15:0] klen,
                              input logic [31:0] vlen, input logic [31:0] elen,
                              input bit corrupt_crc);
        logic [255:0] hdr;
        logic [7:0]   body[$];
        logic [31:0]  crc;
        logic [33:0]  span;
        hdr = '0;
        hdr[63:0]                 = seq;
        hdr[OFF_FP*8 +: 64]       = fp;
        hdr[OFF_ELEN*8 +: 32]     = elen;
        hdr[OFF_VLEN*8 +: 32]     = vlen;
        hdr[OFF_KLEN*8 +: 16]     = klen;
        hdr[OFF_FLAGS*8 +: 16]    = flags;
        span = 34'(HDR_BYTES) + 34'(klen) + 34'(vlen);
        crc  = CRC_INIT;
        for (int i = 0; i < HDR_BYTES; i++) crc = crc32c_shift_in(crc, hdr[8*i +: 8]);
        if (elen >= 32'(HDR_BYTES) && elen <= max_len_cfg && span == 34'(elen)) begin
            repeat (span - 34'(HDR_BYTES)) begin
                body.push_back(8'($urandom));
                crc = crc32c_shift_in(crc, body[$]);
            end
        end
        crc = ~crc;
        if (corrupt_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        hdr[OFF_CRC*8 +: 32] = crc;
        for (int i = 0; i < HDR_BYTES; i++) send_byte(hdr[8*i +: 8]);
        foreach (body[i]) send_byte(body[i]);
    endtask

    // mostly well-formed entries, some bad lengths, bad crcs and junk headers
    task automatic send_random_entry();
        int          pick;
        logic [15:0] k;
        logic [31:0] v;
        logic [31:0] e;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
            k = 16'($urandom_range(0, 48));
            v = $urandom_range(0, 160);
        end else begin
            k = 16'($urandom_range(0, 6));
            v = $urandom_range(0, 14);
        end
        e = 32'(HDR_BYTES) + k + v;
        entries_sent++;
        if (pick < 6) begin
            // junk header, random length fields
            repeat (HDR_BYTES) send_byte(8'($urandom));
        end else begin
            if (pick < 12) begin
                e = $urandom_range(0, HDR_BYTES - 1);
            end else if (pick < 18) begin
                e = e ^ (32'd1 << $urandom_range(0, 31));
            end else if (pick < 22 && max_len_cfg != 32'hFFFF_FFFF) begin
                // consistent sum but over the limit
                e = max_len_cfg + $urandom_range(1, 100);
                v = e - 32'(HDR_BYTES) - k;
            end else if (pick < 30) begin
                k = '0;
                v = '0;
                e = 32'(HDR_BYTES);
            end
            send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                       k, v, e, $urandom_range(0, 7) == 0);
        end
    endtask

    // stop sending and let every pending result come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (entry_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [31:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        max_len_cfg   = value;
        cfg_writes++;
    endtask

    // field extremes and each length and crc outcome
    task automatic test_directed_entries();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_entry('0, '0, '0, 16'd0, 32'd0, 32'd32, 1'b0);
        send_entry('1, '1, '1, 16'd0, 32'd0, 32'd32, 1'b1);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'hA5C3,
                   16'd3, 32'd5, 32'd40, 1'b0);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'h5A3C,
                   16'd2, 32'd7, 32'd41, 1'b1);
        send_entry({$urandom, $urandom}, '1, '0, 16'd1, 32'd0, 32'd33, 1'b0);
        send_entry('0, {$urandom, $urandom}, '1, 16'd0, 32'd1, 32'd33, 1'b0);
        // entry length below the header size
        send_entry('1, '0, 16'h8001, 16'd0, 32'd0, 32'd0, 1'b0);
        send_entry('0, '1, 16'h7FFE, 16'd0, 32'd0, 32'd31, 1'b0);
        // sum does not match entry length
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, '0,
                   16'd0, 32'd0, 32'd33, 1'b0);
        // key plus value overflows 32 bits
        send_entry('1, '1, '1, 16'hFFFF, 32'hFFFF_FFFF,
                   32'(34'(HDR_BYTES) + 34'h0_FFFF + 34'hFFFF_FFFF), 1'b0);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, '1, 16'hFFFF,
                   32'hFFFF_FFFF - 32'(HDR_BYTES) - 32'h0_FFFF + 32'd2,
                   32'hFFFF_FFFF, 1'b0);
        repeat (HDR_BYTES) send_byte(8'($urandom));
        wait_drained();
    endtask

    // limit edges, including limits below the header size
    task automatic test_max_length();
        write_max_length(32'd32);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd0, 32'd0, 32'd32, 1'b0);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd1, 32'd0, 32'd33, 1'b0);
        write_max_length(32'd31);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd0, 32'd0, 32'd32, 1'b0);
        write_max_length(32'd0);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd0, 32'd0, 32'd32, 1'b0);
        write_max_length(32'd100);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd4, 32'd64, 32'd100, 1'b0);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd4, 32'd65, 32'd101, 1'b0);
        write_max_length(32'hFFFF_FFFF);
        send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                   16'd2, 32'd2, 32'd36, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [31:0] max_len);
        int start_bytes;
        int start_entries;
        write_max_length(max_len);
        tx_idle_pct   = tx_pct;
        rx_stall_pct  = rx_pct;
        start_bytes   = bytes_sent;
        start_entries = entries_sent;
        while (bytes_sent - start_bytes < PHASE_BYTES
               || entries_sent - start_entries < PHASE_ENTRIES)
            send_random_entry();
        wait_drained();
    endtask

    // receiver holds off while header-only entries keep coming
    task automatic test_output_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = RX_HOLD_CYCLES;
        repeat (4) begin
            send_entry({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                       16'd0, 32'd0, 32'd32, $urandom_range(0, 3) == 0);
        end
        wait_drained();
    endtask

    // sender waits for each result before the next entry
    task automatic test_drain_pauses();
        tx_idle_pct  = 0;
        rx_stall_pct = 30;
        repeat (4) begin
            send_random_entry();
            wait_drained();
        end
    endtask

    // result transfer check and receiver stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_status, o_sequence_number, o_key_fingerprint,
                   o_entry_flags, o_key_length, o_value_length};
            if (entry_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with none expected, status %0d seq %h",
                             $realtime, got.status, got.sequence_number);
            end else begin
                want = entry_results_q.pop_front();
                if (want.status == STATUS_OK) ok_seen++;
                else if (want.status == STATUS_LEN_ERR) len_err_seen++;
                else crc_err_seen++;
                if (got.status !== want.status
                    || got.sequence_number !== want.sequence_number
                    || got.key_fingerprint !== want.key_fingerprint
                    || got.entry_flags !== want.entry_flags
                    || got.key_length !== want.key_length
                    || got.value_length !== want.value_length) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: expected st %0d seq %h fp %h fl %h kl %h vl %h",
                                 $realtime, want.status, want.sequence_number,
                                 want.key_fingerprint, want.entry_flags,
                                 want.key_length, want.value_length);
                        $display("%0t: actual   st %0d seq %h fp %h fl %h kl %h vl %h",
                                 $realtime, got.status, got.sequence_number,
                                 got.key_fingerprint, got.entry_flags,
                                 got.key_length, got.value_length);
                    end
                end
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_entries();
        test_max_length();
        test_random_traffic(0, 0, 32'hFFFF_FFFF);
        test_random_traffic(67, 0, 32'd64);
        test_random_traffic(0, 67, $urandom_range(32, 400));
        test_random_traffic(8, 8, 32'hFFFF_FFFF);
        test_output_backpressure();
        test_drain_pauses();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (entry_results_q.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", entry_results_q.size());
        end
        $display("run: %0d stream bytes, %0d results (%0d ok, %0d bad length, %0d bad crc)",
                 bytes_sent, ok_seen + len_err_seen + crc_err_seen,
                 ok_seen, len_err_seen, crc_err_seen);
        $display("run: %0d max length writes, idle/stall mixes, long output hold, %0d errors",
                 cfg_writes, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== log_entry_frame_checker.f =====
hw/rtl/lefc_pkg.sv
hw/rtl/lefc_in_stage.sv
hw/rtl/lefc_parser.sv
hw/rtl/lefc_out_stage.sv
hw/rtl/log_entry_frame_checker.sv
hw/rtl/lefc_checker.sv
tb/log_entry_frame_checker_tb.sv
